>>> rtl/yzd_pkg.sv
// yzd_pkg: shared constants, types and tables of the yaz0 stream decompressor
// used by the top level, its checker and the test bench
`timescale 1ns / 1ps
package yzd_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int HEADER_BYTES = 16;
  localparam int OUT_LANES    = 8;
  localparam int LANE_W       = $clog2(OUT_LANES + 1);
  localparam int LANE_IW      = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;

  localparam logic [7:0] LIT_MASK   = 8'h80;
  localparam logic [3:0] NIB_MASK   = 4'h0F;
  localparam logic [8:0] EXTRA_BASE = 9'h012;

  typedef logic [7:0] byte_t;

  localparam byte_t MAGIC [4] = '{8'h59, 8'h61, 8'h7A, 8'h30};

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT_HDR  = 3'd1,
    ST_BAD_MAGIC  = 3'd2,
    ST_SIZE_MISM  = 3'd3,
    ST_CUT_PAIR   = 3'd4,
    ST_CUT_LEN    = 3'd5,
    ST_OFFS_FAR   = 3'd6,
    ST_SHORT_OUT  = 3'd7
  } status_t;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_LAYOUT = 5'b00010,
    PH_ELEM   = 5'b00100,
    PH_PAIR2  = 5'b01000,
    PH_EXTRA  = 5'b10000
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_WR   = 5'b00100,
    S_PFL  = 5'b01000,
    S_FFL  = 5'b10000
  } fsm_t;

endpackage

>>> rtl/yzd_ram.sv
// yzd_ram: generic single write port, single read port ram, registered read
// no dependencies
`timescale 1ns / 1ps
module yzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/yaz0_stream_decompressor_top.sv
// yaz0_stream_decompressor_top: header check, layout decode and copy engine
// depends on yzd_pkg and yzd_ram (history window)
`timescale 1ns / 1ps
// Usage
//   in_*  : one compressed byte per item, in_last on the final byte of a stream.
//   out_* : results of up to 8 decoded bytes, first byte in out_data[7:0];
//           run_last marks the last result of an input item, stream_done with
//           status closes a stream.
//   cfg_* : write of the decoded length the header must state; cfg_ready is
//           always high, write only while idle.
// Flow
//   a literal or a byte that ends a stream goes to the flush state, which loads
//   the result register once out_stall allows; header, layout and leading pair bytes need no flush.
//   back-references copy byte by byte through the single read port of the
//   history ram (read, then write back), with a result of eight bytes handed
//   out whenever the lanes fill; in_stall is high for the whole copy.
// Reset
//   rst_n low clears all control state and sets the decoded length to 1; history
//   contents are left as they are, a stream never reads what it has not written.
// Back-pressure
//   out_stall holds the result register; the engine waits for it and in turn
//   raises in_stall.
module yaz0_stream_decompressor_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_byte,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [8*yzd_pkg::OUT_LANES-1:0] out_data,
  output logic [3:0]              out_count,
  output logic                    run_last,
  output logic                    stream_done,
  output logic [2:0]              status,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [31:0]             cfg_data
);
  import yzd_pkg::*;

  localparam int DW = 8 * OUT_LANES;

  fsm_t       state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic [4:0] hcnt_r, hcnt_nxt;
  logic [31:0] hsize_r, hsize_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [3:0] left_r, left_nxt;
  logic [7:0] pfirst_r, pfirst_nxt;
  logic [7:0] plow_r, plow_nxt;
  logic       magbad_r, magbad_nxt;
  logic       drain_r, drain_nxt;
  logic [31:0] exp_r;
  logic [12:0] off_r, off_nxt;
  logic [8:0] rem_r, rem_nxt;
  logic [DW-1:0] acc_r, acc_nxt;
  logic [LANE_W-1:0] cnt_r, cnt_nxt;
  logic       done_r, done_nxt;
  status_t    stat_r, stat_nxt;
  logic       last_r, last_nxt;

  logic          ov_r, ov_nxt;
  logic [DW-1:0] od_r, od_nxt;
  logic [3:0]    oc_r, oc_nxt;
  logic          orl_r, orl_nxt;
  logic          osd_r, osd_nxt;
  status_t       ost_r, ost_nxt;

  logic              we;
  logic [WIN_AW-1:0] raddr;
  logic [7:0]        wdata;
  logic [7:0]        rdata;
  logic [31:0]       src;

  logic        accept;
  logic        oslot;
  logic [4:0]  hidx1;
  logic [12:0] offs;
  logic        err;
  status_t     err_code;
  logic        lit;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign oslot     = !ov_r || !out_stall;
  assign src       = prod_r - {19'd0, off_r};
  assign raddr     = src[WIN_AW-1:0];

  yzd_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (prod_r[WIN_AW-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    hcnt_nxt   = hcnt_r;
    hsize_nxt  = hsize_r;
    prod_nxt   = prod_r;
    shift_nxt  = shift_r;
    left_nxt   = left_r;
    pfirst_nxt = pfirst_r;
    plow_nxt   = plow_r;
    magbad_nxt = magbad_r;
    drain_nxt  = drain_r;
    off_nxt    = off_r;
    rem_nxt    = rem_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    done_nxt   = done_r;
    stat_nxt   = stat_r;
    last_nxt   = last_r;
    ov_nxt     = ov_r && out_stall;
    od_nxt     = od_r;
    oc_nxt     = oc_r;
    orl_nxt    = orl_r;
    osd_nxt    = osd_r;
    ost_nxt    = ost_r;
    we         = 1'b0;
    wdata      = in_byte;
    hidx1      = hcnt_r + 5'd1;
    offs       = {1'b0, pfirst_r[3:0], plow_r} + 13'd1;
    err        = 1'b0;
    err_code   = ST_OK;
    lit        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt = in_last;
          done_nxt = 1'b0;
          stat_nxt = ST_OK;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          if (drain_r) begin
            if (in_last) begin
              drain_nxt  = 1'b0;
              phase_nxt  = PH_HEADER;
              hcnt_nxt   = '0;
              hsize_nxt  = '0;
              prod_nxt   = '0;
              shift_nxt  = '0;
              left_nxt   = '0;
              pfirst_nxt = '0;
              plow_nxt   = '0;
              magbad_nxt = 1'b0;
            end
          end else if (phase_r == PH_HEADER) begin
            if (hcnt_r < 5'd4) begin
              if (in_byte != MAGIC[hcnt_r[1:0]]) begin
                magbad_nxt = 1'b1;
              end
            end else if (hcnt_r < 5'd8) begin
              hsize_nxt = {hsize_r[23:0], in_byte};
            end
            hcnt_nxt = hidx1;
            if (hidx1 >= 5'(HEADER_BYTES)) begin
              if (exp_r == 32'd0) begin
                done_nxt = 1'b1; stat_nxt = ST_SHORT_HDR;
              end else if (magbad_nxt) begin
                done_nxt = 1'b1; stat_nxt = ST_BAD_MAGIC;
              end else if (hsize_nxt != exp_r) begin
                done_nxt = 1'b1; stat_nxt = ST_SIZE_MISM;
              end else begin
                phase_nxt = PH_LAYOUT;
                if (in_last) begin
                  done_nxt = 1'b1; stat_nxt = ST_SHORT_OUT;
                end
              end
            end else if (in_last) begin
              done_nxt = 1'b1; stat_nxt = ST_SHORT_HDR;
            end
            if (done_nxt) begin
              state_nxt = S_FFL;
            end
          end else if (prod_r >= exp_r) begin
            done_nxt  = 1'b1;
            stat_nxt  = ST_OK;
            state_nxt = S_FFL;
          end else begin
            priority case (1'b1)
              (phase_r == PH_LAYOUT): begin
                shift_nxt = in_byte;
                left_nxt  = 4'd8;
                phase_nxt = PH_ELEM;
              end
              (phase_r == PH_ELEM): begin
                if ((shift_r & LIT_MASK) != 8'd0) begin
                  lit      = 1'b1;
                  we       = 1'b1;
                  prod_nxt = prod_r + 32'd1;
                  acc_nxt  = {{(DW-8){1'b0}}, in_byte};
                  cnt_nxt  = LANE_W'(1);
                end else if (in_last) begin
                  err = 1'b1; err_code = ST_CUT_PAIR;
                end else begin
                  pfirst_nxt = in_byte;
                  phase_nxt  = PH_PAIR2;
                end
              end
              (phase_r == PH_PAIR2): begin
                plow_nxt = in_byte;
                offs     = {1'b0, pfirst_r[3:0], in_byte} + 13'd1;
                if (pfirst_r[7:4] == 4'd0) begin
                  if (in_last) begin
                    err = 1'b1; err_code = ST_CUT_LEN;
                  end else begin
                    phase_nxt = PH_EXTRA;
                  end
                end else if ({19'd0, offs} > prod_r) begin
                  err = 1'b1; err_code = ST_OFFS_FAR;
                end else begin
                  off_nxt   = offs;
                  rem_nxt   = {5'd0, pfirst_r[7:4]} + 9'd2;
                  state_nxt = S_RD;
                end
              end
              default: begin
                if ({19'd0, offs} > prod_r) begin
                  err = 1'b1; err_code = ST_OFFS_FAR;
                end else begin
                  off_nxt   = offs;
                  rem_nxt   = {1'b0, in_byte} + EXTRA_BASE;
                  state_nxt = S_RD;
                end
              end
            endcase
            if (lit || state_nxt == S_RD) begin
              shift_nxt = {shift_r[6:0], 1'b0};
              left_nxt  = (left_r != 4'd0) ? left_r - 4'd1 : 4'd0;
              phase_nxt = (left_nxt == 4'd0) ? PH_LAYOUT : PH_ELEM;
            end
            if (state_nxt != S_RD) begin
              if (err) begin
                done_nxt = 1'b1; stat_nxt = err_code;
              end else if (prod_nxt >= exp_r) begin
                done_nxt = 1'b1; stat_nxt = ST_OK;
              end else if (in_last) begin
                done_nxt = 1'b1; stat_nxt = ST_SHORT_OUT;
              end
              if (done_nxt || lit) begin
                state_nxt = S_FFL;
              end
            end
          end
        end
      end
      S_RD: begin
        if (rem_r == 9'd0 || prod_r >= exp_r) begin
          if (prod_r >= exp_r) begin
            done_nxt = 1'b1; stat_nxt = ST_OK;
          end else if (last_r) begin
            done_nxt = 1'b1; stat_nxt = ST_SHORT_OUT;
          end
          state_nxt = S_FFL;
        end else if (cnt_r == LANE_W'(OUT_LANES)) begin
          state_nxt = S_PFL;
        end else begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        we       = 1'b1;
        wdata    = rdata;
        acc_nxt[cnt_r[LANE_IW-1:0]*8 +: 8] = rdata;
        cnt_nxt  = cnt_r + LANE_W'(1);
        prod_nxt = prod_r + 32'd1;
        rem_nxt  = rem_r - 9'd1;
        state_nxt = S_RD;
      end
      S_PFL: begin
        if (oslot) begin
          ov_nxt    = 1'b1;
          od_nxt    = acc_r;
          oc_nxt    = 4'(cnt_r);
          orl_nxt   = 1'b0;
          osd_nxt   = 1'b0;
          ost_nxt   = ST_OK;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_RD;
        end
      end
      default: begin
        if (cnt_r != '0 || done_r) begin
          if (oslot) begin
            ov_nxt    = 1'b1;
            od_nxt    = acc_r;
            oc_nxt    = 4'(cnt_r);
            orl_nxt   = 1'b1;
            osd_nxt   = done_r;
            ost_nxt   = done_r ? stat_r : ST_OK;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
        if (state_nxt == S_IDLE && done_r) begin
          if (last_r) begin
            phase_nxt  = PH_HEADER;
            hcnt_nxt   = '0;
            hsize_nxt  = '0;
            prod_nxt   = '0;
            shift_nxt  = '0;
            left_nxt   = '0;
            pfirst_nxt = '0;
            plow_nxt   = '0;
            magbad_nxt = 1'b0;
          end else begin
            drain_nxt = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= PH_HEADER;
      hcnt_r   <= '0;
      hsize_r  <= '0;
      prod_r   <= '0;
      shift_r  <= '0;
      left_r   <= '0;
      pfirst_r <= '0;
      plow_r   <= '0;
      magbad_r <= 1'b0;
      drain_r  <= 1'b0;
      exp_r    <= 32'd1;
      cnt_r    <= '0;
      done_r   <= 1'b0;
      last_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      hcnt_r   <= hcnt_nxt;
      hsize_r  <= hsize_nxt;
      prod_r   <= prod_nxt;
      shift_r  <= shift_nxt;
      left_r   <= left_nxt;
      pfirst_r <= pfirst_nxt;
      plow_r   <= plow_nxt;
      magbad_r <= magbad_nxt;
      drain_r  <= drain_nxt;
      if (cfg_valid && cfg_ready) begin
        exp_r <= cfg_data;
      end
      cnt_r    <= cnt_nxt;
      done_r   <= done_nxt;
      last_r   <= last_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r  <= off_nxt;
    rem_r  <= rem_nxt;
    acc_r  <= acc_nxt;
    stat_r <= stat_nxt;
    od_r   <= od_nxt;
    oc_r   <= oc_nxt;
    orl_r  <= orl_nxt;
    osd_r  <= osd_nxt;
    ost_r  <= ost_nxt;
  end

  assign out_valid   = ov_r;
  assign out_data    = od_r;
  assign out_count   = oc_r;
  assign run_last    = orl_r;
  assign stream_done = osd_r;
  assign status      = ost_r;

endmodule

>>> rtl/yzd_checker.sv
// yzd_checker: port level assertions for the yaz0 stream decompressor
// depends on yzd_pkg; bound to yaz0_stream_decompressor_top
`timescale 1ns / 1ps
module yzd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [8*yzd_pkg::OUT_LANES-1:0] out_data,
  input logic [3:0]  out_count,
  input logic        run_last,
  input logic        stream_done,
  input logic [2:0]  status
);
  import yzd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data) && $stable(out_count))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !stream_done |-> status == 3'd0)
    else $error("status set without stream end");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && stream_done |-> run_last)
    else $error("stream end not on last result of item");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count == 4'd0 |-> stream_done)
    else $error("empty result without stream end");

  a_partial: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !run_last |-> out_count == 4'(OUT_LANES))
    else $error("partial result in mid item");

endmodule

bind yaz0_stream_decompressor_top yzd_checker u_yzd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_data    (out_data),
  .out_count   (out_count),
  .run_last    (run_last),
  .stream_done (stream_done),
  .status      (status)
);

>>> verif/yaz0_stream_decompressor_top_test.sv
// yaz0_stream_decompressor_top_test: self-checking bench for the yaz0 stream decompressor
// directed table then random compressed streams, checked against a built-in decoder
// depends on yzd_pkg and the yaz0_stream_decompressor_top rtl
`timescale 1ns / 1ps
module yaz0_stream_decompressor_top_test;
  import yzd_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 230;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        run_last;
    logic        done;
    status_t     st;
  } decoded_t;

  typedef struct {
    bit          is_cfg;
    logic [31:0] value;
    bit          last;
    bit          fixed;
    status_t     st;
  } row_t;

  typedef struct {
    byte_t b;
    bit    last;
  } comp_byte_t;

  typedef enum int {
    K_GOOD, K_SHORT_HDR, K_HDR_ONLY, K_BAD_MAGIC, K_SIZE_MISM,
    K_CUT_PAIR, K_CUT_LEN, K_FAR, K_SHORT_OUT
  } stream_kind_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  in_byte = 0;
  logic        in_last = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [63:0] out_data;
  logic [3:0]  out_count;
  logic        run_last;
  logic        stream_done;
  logic [2:0]  status;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [31:0] cfg_data = 0;

  decoded_t    decoded_q[$];
  comp_byte_t  stream_q[$];
  int          failures = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          calm = 0;

  // decoder state
  byte_t       window[WINDOW_DEPTH];
  logic [31:0] size_reg;
  int          hdr_cnt;
  logic [31:0] hdr_size;
  logic [31:0] produced;
  byte_t       layout;
  int          layout_left;
  phase_t      ph;
  byte_t       pair_first;
  byte_t       pair_low;
  bit          magic_bad;
  bit          draining;
  byte_t       step_bytes[$];

  yaz0_stream_decompressor_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .out_count(out_count), .run_last(run_last), .stream_done(stream_done),
    .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void restart_stream();
    hdr_cnt = 0;
    hdr_size = 0;
    produced = 0;
    layout = 0;
    layout_left = 0;
    ph = PH_HEADER;
    pair_first = 0;
    pair_low = 0;
    magic_bad = 0;
    draining = 0;
  endfunction

  function automatic void emit(byte_t b);
    window[produced[WIN_AW-1:0]] = b;
    produced = produced + 1;
    step_bytes.push_back(b);
  endfunction

  function automatic void next_element();
    layout = layout << 1;
    if (layout_left > 0) layout_left--;
    ph = (layout_left == 0) ? PH_LAYOUT : PH_ELEM;
  endfunction

  // returns 1 when the offset reaches beyond what has been produced
  function automatic bit copy_back(int unsigned len);
    logic [31:0] offset;
    logic [31:0] src;
    offset = {20'd0, pair_first[3:0], pair_low} + 1;
    if (offset > produced) return 1;
    for (int unsigned i = 0; i < len && produced < size_reg; i++) begin
      src = produced - offset;
      emit(window[src[WIN_AW-1:0]]);
    end
    next_element();
    return 0;
  endfunction

  function automatic void decode_byte(byte_t b, bit last);
    bit       done;
    bit       bad;
    status_t  st;
    int       pos;
    int       nres;
    decoded_t r;
    done = 0;
    bad = 0;
    st = ST_OK;
    step_bytes.delete();
    if (draining) begin
      if (last) restart_stream();
      return;
    end
    if (ph == PH_HEADER) begin
      if (hdr_cnt < 4) begin
        if (b != MAGIC[hdr_cnt]) magic_bad = 1;
      end else if (hdr_cnt < 8) begin
        hdr_size = {hdr_size[23:0], b};
      end
      hdr_cnt++;
      if (hdr_cnt >= HEADER_BYTES) begin
        done = 1;
        if (size_reg == 0) st = ST_SHORT_HDR;
        else if (magic_bad) st = ST_BAD_MAGIC;
        else if (hdr_size != size_reg) st = ST_SIZE_MISM;
        else begin
          ph = PH_LAYOUT;
          done = last;
          st = ST_SHORT_OUT;
        end
      end else if (last) begin
        done = 1;
        st = ST_SHORT_HDR;
      end
    end else if (produced >= size_reg) begin
      done = 1;
    end else begin
      case (ph)
        PH_LAYOUT: begin
          layout = b;
          layout_left = 8;
          ph = PH_ELEM;
        end
        PH_ELEM: begin
          if ((layout & LIT_MASK) != 0) begin
            emit(b);
            next_element();
          end else if (last) begin
            bad = 1;
            st = ST_CUT_PAIR;
          end else begin
            pair_first = b;
            ph = PH_PAIR2;
          end
        end
        PH_PAIR2: begin
          pair_low = b;
          if (pair_first[7:4] == 0) begin
            if (last) begin
              bad = 1;
              st = ST_CUT_LEN;
            end else ph = PH_EXTRA;
          end else if (copy_back(pair_first[7:4] + 2)) begin
            bad = 1;
            st = ST_OFFS_FAR;
          end
        end
        default: begin
          if (copy_back(b + EXTRA_BASE)) begin
            bad = 1;
            st = ST_OFFS_FAR;
          end
        end
      endcase
      if (bad) done = 1;
      else if (produced >= size_reg) begin
        done = 1;
        st = ST_OK;
      end else if (last) begin
        done = 1;
        st = ST_SHORT_OUT;
      end
    end
    pos = 0;
    nres = 0;
    while (pos < step_bytes.size() || (done && nres == 0)) begin
      r.data = 0;
      r.count = 0;
      while (r.count < OUT_LANES && pos < step_bytes.size()) begin
        r.data[8*r.count +: 8] = step_bytes[pos];
        r.count++;
        pos++;
      end
      r.run_last = (pos >= step_bytes.size());
      r.done = r.run_last && done;
      r.st = r.done ? st : ST_OK;
      decoded_q.push_back(r);
      nres++;
    end
    if (done) begin
      if (last) restart_stream();
      else draining = 1;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(byte_t b, bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_byte <= b;
    in_last <= last;
    do @(posedge clk); while (in_stall);
    decode_byte(b, last);
  endtask

  task automatic write_size(logic [31:0] value);
    in_valid <= 0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    size_reg = value;
  endtask

  function automatic void add(byte_t b);
    comp_byte_t c;
    c.b = b;
    c.last = 0;
    stream_q.push_back(c);
  endfunction

  function automatic void build_stream(logic [31:0] size, stream_kind_t kind, int budget);
    logic [31:0] hsize;
    logic [31:0] prod;
    logic [31:0] reach;
    int          keep;
    int          stop_at;
    int          off;
    int          nib;
    int          len;
    byte_t       lay;
    byte_t       elems[$];
    bit          ended;
    stream_q.delete();
    hsize = (kind == K_SIZE_MISM) ? size + $urandom_range(1, 255) : size;
    for (int i = 0; i < 4; i++) add(MAGIC[i]);
    if (kind == K_BAD_MAGIC) stream_q[$urandom_range(0, 3)].b ^= 8'(1 << $urandom_range(0, 7));
    for (int i = 3; i >= 0; i--) add(hsize[8*i +: 8]);
    for (int i = 0; i < 8; i++) add(8'($urandom_range(0, 255)));
    if (kind == K_SHORT_HDR) begin
      keep = $urandom_range(1, 15);
      while (stream_q.size() > keep) void'(stream_q.pop_back());
      stream_q[$].last = 1;
      return;
    end
    if (kind == K_HDR_ONLY) begin
      stream_q[$].last = 1;
      return;
    end
    if (kind == K_BAD_MAGIC || kind == K_SIZE_MISM) begin
      repeat ($urandom_range(1, 4)) add(8'($urandom_range(0, 255)));
      stream_q[$].last = 1;
      return;
    end
    prod = 0;
    ended = 0;
    stop_at = (kind == K_SHORT_OUT) ? $urandom_range(1, 40) : ((budget < 24) ? 24 : budget);
    while (!ended && prod < size && stream_q.size() < stop_at + 16) begin
      lay = 0;
      elems.delete();
      for (int k = 7; k >= 0 && !ended && prod < size; k--) begin
        if ($urandom_range(0, 2) != 0 || (prod == 0 && kind != K_FAR)) begin
          lay[k] = 1;
          elems.push_back(8'($urandom_range(0, 255)));
          prod++;
        end else begin
          reach = (prod > WINDOW_DEPTH) ? WINDOW_DEPTH : prod;
          if (reach == 0 || (kind == K_FAR && $urandom_range(0, 1) == 0
              && prod < WINDOW_DEPTH)) begin
            off = $urandom_range(prod, (prod + 64 > 4095) ? 4095 : prod + 64);
            ended = 1;
          end else off = $urandom_range(0, reach - 1);
          nib = $urandom_range(0, 15);
          elems.push_back({4'(nib), 4'(off >> 8)});
          if (kind == K_CUT_PAIR && $urandom_range(0, 2) == 0) begin
            ended = 1;
            break;
          end
          elems.push_back(off[7:0]);
          if (nib == 0) begin
            if (kind == K_CUT_LEN && $urandom_range(0, 1) == 0) begin
              ended = 1;
              break;
            end
            len = $urandom_range(0, 255);
            elems.push_back(8'(len));
            len = len + EXTRA_BASE;
          end else len = nib + 2;
          prod = prod + len;
        end
      end
      add(lay);
      foreach (elems[i]) add(elems[i]);
    end
    if (!ended && kind != K_SHORT_OUT)
      repeat ($urandom_range(0, 3)) add(8'($urandom_range(0, 255)));
    stream_q[$].last = 1;
  endfunction

  // directed stimulus: config rows mixed with compressed bytes, in the order applied
  row_t rows[$] = '{
    '{1, 32'd1, 0, 0, ST_OK},
    '{0, 8'h59, 1, 1, ST_SHORT_HDR},
    '{1, 32'hFFFFFFFF, 0, 0, ST_OK},
    '{1, 32'd3, 0, 0, ST_OK},
    '{0, 8'h59, 0, 0, ST_OK}, '{0, 8'h61, 0, 0, ST_OK},
    '{0, 8'h7A, 0, 0, ST_OK}, '{0, 8'h30, 0, 0, ST_OK},
    '{0, 8'h00, 0, 0, ST_OK}, '{0, 8'h00, 0, 0, ST_OK},
    '{0, 8'h00, 0, 0, ST_OK}, '{0, 8'h03, 0, 0, ST_OK},
    '{0, 8'hFF, 0, 0, ST_OK}, '{0, 8'hFF, 0, 0, ST_OK},
    '{0, 8'hFF, 0, 0, ST_OK}, '{0, 8'hFF, 0, 0, ST_OK},
    '{0, 8'hFF, 0, 0, ST_OK}, '{0, 8'hFF, 0, 0, ST_OK},
    '{0, 8'hFF, 0, 0, ST_OK}, '{0, 8'hFF, 0, 0, ST_OK},
    '{0, 8'h80, 0, 0, ST_OK},
    '{0, 8'hFF, 0, 0, ST_OK},
    '{0, 8'h00, 0, 0, ST_OK},
    '{0, 8'h00, 0, 0, ST_OK},
    '{0, 8'hFF, 1, 0, ST_OK}
  };

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else if (!calm && $urandom_range(0, 9) < 3) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    decoded_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $error("result with nothing expected: data %h count %0d", out_data, out_count);
        failures++;
      end else begin
        e = decoded_q.pop_front();
        if (out_data !== e.data) begin
          $error("out_data expected %h actual %h", e.data, out_data);
          failures++;
        end
        if (out_count !== e.count) begin
          $error("out_count expected %0d actual %0d", e.count, out_count);
          failures++;
        end
        if (run_last !== e.run_last) begin
          $error("run_last expected %0d actual %0d", e.run_last, run_last);
          failures++;
        end
        if (stream_done !== e.done) begin
          $error("stream_done expected %0d actual %0d", e.done, stream_done);
          failures++;
        end
        if (status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, status);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("yaz0_stream_decompressor_top_test: FAIL");
      $finish;
    end
  end

  initial begin
    int           sent;
    int           n0;
    int           r;
    logic [31:0]  size;
    stream_kind_t kind;
    decoded_t     typed;
    size_reg = 1;
    restart_stream();
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_size(rows[i].value);
      else begin
        n0 = decoded_q.size();
        send_byte(rows[i].value[7:0], rows[i].last);
        if (rows[i].fixed) begin
          while (decoded_q.size() > n0) void'(decoded_q.pop_back());
          typed = '{64'd0, 4'd0, 1'b1, 1'b1, rows[i].st};
          decoded_q.push_back(typed);
        end
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 60) kind = K_GOOD;
      else kind = stream_kind_t'($urandom_range(K_SHORT_HDR, K_SHORT_OUT));
      r = $urandom_range(0, 19);
      if (r == 0) size = 1;
      else if (r == 1) size = 32'hFFFFFFFF;
      else if (r < 4) size = $urandom_range(200, 600);
      else size = $urandom_range(1, 40);
      calm = ($urandom_range(0, 3) == 0);
      write_size(size);
      build_stream(size, kind, RANDOM_ITEMS - sent);
      foreach (stream_q[i]) send_byte(stream_q[i].b, stream_q[i].last);
      sent += stream_q.size();
    end
    in_valid <= 0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (failures == 0) $display("yaz0_stream_decompressor_top_test: PASS");
    else $display("yaz0_stream_decompressor_top_test: FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/yzd_pkg.sv
rtl/yzd_ram.sv
rtl/yaz0_stream_decompressor_top.sv
rtl/yzd_checker.sv
verif/yaz0_stream_decompressor_top_test.sv
